// ===== sv/rarmt_pkg.sv =====
package rarmt_pkg;

    // tree geometry
    localparam int SIZE       = 1024;
    localparam int LEVELS     = 10;
    localparam int NODE_DEPTH = 2 * SIZE;
    localparam int ADDR_W     = 11;
    localparam int LVL_W      = 4;
    localparam int POS_W      = 10;
    localparam int RANGE_W    = 11;
    localparam int VAL_W      = 32;
    localparam int AMT_W      = 16;

    // item kinds
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // one tree node as stored in memory
    typedef struct packed {
        logic [VAL_W-1:0] max;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] pend;
    } node_t;

    // memory write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        node_t             data;
    } ram_wr_t;

    // item handed to the tree walker
    typedef struct packed {
        logic               valid;
        logic               action;
        logic [RANGE_W-1:0] start;
        logic [RANGE_W-1:0] stop;
        logic [AMT_W-1:0]   amount;
    } walk_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] max_value;
        logic [POS_W-1:0] max_position;
        logic             empty_range;
        logic             overflow;
    } result_t;

    // walker status and finished result
    typedef struct packed {
        logic    ready;
        logic    valid;
        result_t result;
    } walk_rsp_t;

endpackage

// ===== sv/rarmt_node_ram.sv =====
module rarmt_node_ram
    import rarmt_pkg::*;
(
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  logic [ADDR_W-1:0] raddr,
    output node_t             rdata
);

    node_t mem [NODE_DEPTH];
    node_t rdata_reg;

    // one write and one read per cycle, write data forwarded on a same-entry read
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (wr.we && wr.addr == raddr) begin
            rdata_reg <= wr.data;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rarmt_walker.sv =====
module rarmt_walker
    import rarmt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  walk_req_t req,
    input  logic      res_ready,
    output walk_rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DOWN,
        ST_UP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // node index at a level that holds leaf position x
    function automatic logic [ADDR_W-1:0] node_at(input logic [POS_W-1:0] x,
                                                  input logic [LVL_W-1:0] lvl);
        logic [ADDR_W-1:0] head;
        logic [ADDR_W-1:0] tail;
        head = ADDR_W'(1) << lvl;
        tail = ADDR_W'(x) >> (LEVELS - int'(lvl));
        return head | tail;
    endfunction

    // node holding x at a level only partly overlaps [a,b)
    function automatic logic node_partial(input logic [POS_W-1:0] x,
                                          input logic [LVL_W-1:0] lvl,
                                          input logic [RANGE_W-1:0] a,
                                          input logic [RANGE_W-1:0] b);
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        lo = ((ADDR_W+1)'(x) >> (LEVELS - int'(lvl))) << (LEVELS - int'(lvl));
        hi = lo + ((ADDR_W+1)'(1) << (LEVELS - int'(lvl)));
        return !(lo >= (ADDR_W+1)'(a) && hi <= (ADDR_W+1)'(b));
    endfunction

    // rightmost leaf of a node span, reset value of its max position
    function automatic logic [POS_W-1:0] rightmost(input logic [ADDR_W-1:0] addr);
        logic [LVL_W-1:0] lv;
        logic [ADDR_W:0]  edge_pos;
        lv = '0;
        for (int i = 0; i < ADDR_W; i++) begin
            if (addr[i]) begin
                lv = LVL_W'(i);
            end
        end
        edge_pos = (((ADDR_W+1)'(addr) + (ADDR_W+1)'(1)) << (LEVELS - int'(lv)))
                   - (ADDR_W+1)'(1);
        return edge_pos[POS_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               action_reg;
    logic               empty_reg;
    logic [RANGE_W-1:0] a_reg;
    logic [RANGE_W-1:0] b_reg;
    logic [VAL_W-1:0]   amt_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [1:0]         slot_reg;
    logic [LVL_W-1:0]   up_lvl_reg;
    logic [1:0]         up_slot_reg;
    logic               p_valid_reg;
    logic [LVL_W-1:0]   p_lvl_reg;
    logic [ADDR_W-1:0]  p_addr_reg;
    logic               p_selb_reg;
    logic               u_valid_reg;
    logic               u_is_rc_reg;
    logic [ADDR_W-1:0]  u_target_reg;
    node_t              lc_reg;
    logic [VAL_W-1:0]   carry_reg [2][2];
    logic               ovf_reg;
    logic               found_reg;
    logic [VAL_W-1:0]   best_val_reg;
    logic [POS_W-1:0]   best_pos_reg;

    logic [POS_W-1:0]   a_pos;
    logic [POS_W-1:0]   bm1;
    logic [RANGE_W-1:0] clip_end;

    assign a_pos    = a_reg[POS_W-1:0];
    assign bm1      = POS_W'(b_reg - RANGE_W'(1));
    assign clip_end = (req.stop > RANGE_W'(SIZE)) ? RANGE_W'(SIZE) : req.stop;

    // down walk: children of the partial nodes one level up
    logic [LVL_W-1:0]  dn_par_lvl;
    logic [ADDR_W-1:0] dn_pa, dn_pb, dn_addr;
    logic              dn_pa_part, dn_pb_use, dn_valid;

    always_comb begin
        dn_par_lvl = LVL_W'(lvl_reg - 1'b1);
        dn_pa      = node_at(a_pos, dn_par_lvl);
        dn_pb      = node_at(bm1, dn_par_lvl);
        dn_pa_part = node_partial(a_pos, dn_par_lvl, a_reg, b_reg);
        dn_pb_use  = node_partial(bm1, dn_par_lvl, a_reg, b_reg) && (dn_pb != dn_pa);
        if (lvl_reg == '0) begin
            dn_addr  = ADDR_W'(1);
            dn_valid = (slot_reg == 2'd0);
        end else begin
            case (slot_reg)
                2'd0, 2'd1: begin
                    dn_addr  = {dn_pa[ADDR_W-2:0], slot_reg[0]};
                    dn_valid = dn_pa_part;
                end
                2'd2, 2'd3: begin
                    dn_addr  = {dn_pb[ADDR_W-2:0], slot_reg[0]};
                    dn_valid = dn_pb_use;
                end
                default: begin
                    dn_addr  = '0;
                    dn_valid = 1'b0;
                end
            endcase
        end
    end

    // up walk: children of each partial node, deepest level first
    logic [ADDR_W-1:0] up_a, up_b, up_target, up_addr;
    logic              up_a_part, up_b_use, up_valid;

    always_comb begin
        up_a      = node_at(a_pos, up_lvl_reg);
        up_b      = node_at(bm1, up_lvl_reg);
        up_a_part = node_partial(a_pos, up_lvl_reg, a_reg, b_reg);
        up_b_use  = node_partial(bm1, up_lvl_reg, a_reg, b_reg) && (up_b != up_a);
        up_target = up_slot_reg[1] ? up_b : up_a;
        up_valid  = up_slot_reg[1] ? up_b_use : up_a_part;
        up_addr   = {up_target[ADDR_W-2:0], up_slot_reg[0]};
    end

    // node memory
    ram_wr_t           wr;
    logic [ADDR_W-1:0] raddr;
    node_t             rd;

    assign raddr = (state_reg == ST_DOWN) ? dn_addr : up_addr;

    rarmt_node_ram u_ram (
        .aclk  (aclk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rd)
    );

    // down processing: apply carried add, then cover, pass by or split
    logic [VAL_W-1:0] pc_carry, em, ep;
    logic [ADDR_W:0]  sp_lo, sp_hi;
    logic             covered, outside, partial;
    logic [VAL_W:0]   ovf_sum;
    logic             add_ovf;
    logic             is_a_node, is_b_node;
    logic             better;
    node_t            dn_wdata;

    always_comb begin
        pc_carry = (p_lvl_reg == '0) ? '0 : carry_reg[~p_lvl_reg[0]][p_selb_reg];
        em       = rd.max + pc_carry;
        ep       = rd.pend + pc_carry;
        sp_lo    = ((ADDR_W+1)'(p_addr_reg) ^ ((ADDR_W+1)'(1) << p_lvl_reg))
                   << (LEVELS - int'(p_lvl_reg));
        sp_hi    = sp_lo + ((ADDR_W+1)'(1) << (LEVELS - int'(p_lvl_reg)));
        covered  = sp_lo >= (ADDR_W+1)'(a_reg) && sp_hi <= (ADDR_W+1)'(b_reg);
        outside  = sp_hi <= (ADDR_W+1)'(a_reg) || (ADDR_W+1)'(b_reg) <= sp_lo;
        partial  = !covered && !outside;
        ovf_sum  = {em[VAL_W-1], em} + {amt_reg[VAL_W-1], amt_reg};
        add_ovf  = ovf_sum[VAL_W] ^ ovf_sum[VAL_W-1];
        is_a_node = (p_addr_reg == node_at(a_pos, p_lvl_reg));
        is_b_node = (p_addr_reg == node_at(bm1, p_lvl_reg));
        better   = !found_reg || ($signed(em) > $signed(best_val_reg))
                   || (em == best_val_reg && rd.pos > best_pos_reg);
        dn_wdata = '{max: em, pos: rd.pos, pend: ep};
        if (covered && action_reg == ACT_ADD) begin
            dn_wdata.max  = em + amt_reg;
            dn_wdata.pend = ep + amt_reg;
        end else if (partial) begin
            dn_wdata.pend = '0;
        end
    end

    // up processing: larger child wins, right child on ties
    node_t up_wdata;

    always_comb begin
        if ($signed(rd.max) >= $signed(lc_reg.max)) begin
            up_wdata = '{max: rd.max, pos: rd.pos, pend: '0};
        end else begin
            up_wdata = '{max: lc_reg.max, pos: lc_reg.pos, pend: '0};
        end
    end

    // write port select
    always_comb begin
        wr = '0;
        if (state_reg == ST_CLEAR) begin
            wr.we   = 1'b1;
            wr.addr = clr_addr_reg;
            wr.data = '{max: '0, pos: rightmost(clr_addr_reg), pend: '0};
        end else if (p_valid_reg) begin
            wr.we   = 1'b1;
            wr.addr = p_addr_reg;
            wr.data = dn_wdata;
        end else if (u_valid_reg && u_is_rc_reg) begin
            wr.we   = 1'b1;
            wr.addr = u_target_reg;
            wr.data = up_wdata;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(NODE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req.valid) begin
                    state_next = (req.start >= clip_end) ? ST_DONE : ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (lvl_reg == LVL_W'(LEVELS) && slot_reg == 2'd3) begin
                    state_next = (action_reg == ACT_QUERY) ? ST_DRAIN : ST_UP;
                end
            end
            ST_UP: begin
                if (up_lvl_reg == '0 && up_slot_reg == 2'd3) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered walk context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            p_valid_reg  <= 1'b0;
            u_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == ST_DOWN) && dn_valid;
            u_valid_reg <= (state_reg == ST_UP) && up_valid;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end

        p_lvl_reg    <= lvl_reg;
        p_addr_reg   <= dn_addr;
        p_selb_reg   <= slot_reg[1];
        u_is_rc_reg  <= up_slot_reg[0];
        u_target_reg <= up_target;

        // take a new word
        if (state_reg == ST_IDLE && req.valid) begin
            action_reg <= req.action;
            a_reg      <= req.start;
            b_reg      <= clip_end;
            amt_reg    <= {{(VAL_W-AMT_W){req.amount[AMT_W-1]}}, req.amount};
            empty_reg  <= (req.start >= clip_end);
            lvl_reg    <= '0;
            slot_reg   <= '0;
            up_lvl_reg <= LVL_W'(LEVELS - 1);
            up_slot_reg <= '0;
            ovf_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end

        // step through levels going down
        if (state_reg == ST_DOWN) begin
            if (lvl_reg == '0) begin
                lvl_reg <= LVL_W'(1);
            end else begin
                slot_reg <= slot_reg + 1'b1;
                if (slot_reg == 2'd3 && lvl_reg != LVL_W'(LEVELS)) begin
                    lvl_reg <= lvl_reg + 1'b1;
                end
            end
        end

        // step through levels going up
        if (state_reg == ST_UP) begin
            up_slot_reg <= up_slot_reg + 1'b1;
            if (up_slot_reg == 2'd3 && up_lvl_reg != '0) begin
                up_lvl_reg <= up_lvl_reg - 1'b1;
            end
        end

        // node results of the down walk
        if (p_valid_reg) begin
            if (partial) begin
                if (is_a_node) begin
                    carry_reg[p_lvl_reg[0]][0] <= ep;
                end
                if (is_b_node) begin
                    carry_reg[p_lvl_reg[0]][1] <= ep;
                end
            end
            if (covered && action_reg == ACT_ADD && add_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (covered && action_reg == ACT_QUERY && better) begin
                found_reg    <= 1'b1;
                best_val_reg <= em;
                best_pos_reg <= rd.pos;
            end
        end

        // left child held for the pull up
        if (u_valid_reg && !u_is_rc_reg) begin
            lc_reg <= rd;
        end
    end

    // status and result
    always_comb begin
        rsp        = '0;
        rsp.ready  = (state_reg == ST_IDLE);
        rsp.valid  = (state_reg == ST_DONE);
        if (empty_reg) begin
            rsp.result.empty_range = 1'b1;
        end else if (action_reg == ACT_QUERY) begin
            rsp.result.max_value    = best_val_reg;
            rsp.result.max_position = best_pos_reg;
        end else begin
            rsp.result.overflow = ovf_reg;
        end
    end

`ifndef SYNTH
    // down and up walks never share the write port
    a_wr_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(p_valid_reg && u_valid_reg && u_is_rc_reg))
        else $error("down and up writes collide");

    // overflow only reported for adds
    a_ovf_add_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && rsp.result.overflow) |-> (action_reg == ACT_ADD))
        else $error("overflow flagged on a query");

    // query position lies in the clipped range
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && action_reg == ACT_QUERY && !empty_reg)
        |-> (RANGE_W'(best_pos_reg) >= a_reg && RANGE_W'(best_pos_reg) < b_reg))
        else $error("query position outside range");

    // a walk only starts from idle
    a_walk_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_DOWN) |-> $past(state_reg == ST_IDLE))
        else $error("walk started outside idle");
`endif

endmodule

// ===== sv/range_add_range_max_tree.sv =====
// The down walk reads four node slots per level below the root via the single memory read port;
// adds then pull maxima back up, two child reads per partial node at each level.
// One word is in the walk at a time: the next word is taken only once the last result is passed on.
// Reset: a clearing pass writes all 2048 tree nodes, one per cycle, with s_tready low.
module range_add_range_max_tree
    import rarmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // range_start[10:0], range_end[21:11], add_amount[37:22]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // max_value[31:0], max_position[41:32]
    output logic [1:0]  m_tuser    // empty_range[0], overflow[1]
);

    walk_req_t req;
    walk_rsp_t rsp;
    logic      res_ready;
    logic      out_valid_reg;
    result_t   out_reg;

    // unpack input word
    always_comb begin
        req        = '0;
        req.valid  = s_tvalid;
        req.action = s_tuser;
        req.start  = s_tdata[10:0];
        req.stop   = s_tdata[21:11];
        req.amount = s_tdata[37:22];
    end

    assign s_tready  = rsp.ready;
    assign res_ready = !out_valid_reg || m_tready;

    rarmt_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .res_ready (res_ready),
        .rsp       (rsp)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rsp.valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (rsp.valid && res_ready) begin
            out_reg <= rsp.result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.max_position, out_reg.max_value};
    assign m_tuser  = {out_reg.overflow, out_reg.empty_range};

endmodule
